@@ design/lmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scanner package
// Field widths, command codes and the control structures that are shared
// by the scanner modules.
// ----------------------------------------------------------------------------
package lmcs_pkg;

    localparam int COLUMN_W    = 5;
    localparam int ROW_W       = 3;
    localparam int CMD_W       = 2;
    localparam int SCAN_W      = 5;
    localparam int DWELL_W     = 16;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd500;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic row_data;
        logic row_clock;
        logic latch;
        logic col_data;
        logic col_clock;
    } t_pins;

    localparam t_pins PINS_RESET = '{
        row_data:  1'b0,
        row_clock: 1'b0,
        latch:     1'b1,
        col_data:  1'b0,
        col_clock: 1'b0
    };

    typedef struct packed {
        logic                write;
        logic                clear;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                pixel_on;
    } t_fb_wr;

endpackage

@@ design/lmcs_if.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scanner channels
// Valid/ready channels for command transactions and pin-level results.
// ----------------------------------------------------------------------------
interface lmcs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lmcs_pkg::CMD_W-1:0]    command;
    logic [lmcs_pkg::COLUMN_W-1:0] column;
    logic [lmcs_pkg::ROW_W-1:0]    row;
    logic                          pixel_on;

    modport source (output valid, command, column, row, pixel_on, input ready);
    modport sink   (input valid, command, column, row, pixel_on, output ready);
endinterface

interface lmcs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        row_data_pin;
    logic                        row_clock_pin;
    logic                        latch_pin;
    logic                        column_data_pin;
    logic                        column_clock_pin;
    logic [lmcs_pkg::SCAN_W-1:0] scan_column;

    modport source (output valid, row_data_pin, row_clock_pin, latch_pin,
                    column_data_pin, column_clock_pin, scan_column, input ready);
    modport sink   (input valid, row_data_pin, row_clock_pin, latch_pin,
                    column_data_pin, column_clock_pin, scan_column, output ready);
endinterface

@@ design/lmcs_frame_buffer.sv @@
// ----------------------------------------------------------------------------
// LED matrix frame buffer
// One word of pixels per column, with single-pixel writes, a full clear
// and an asynchronous read of the column being scanned.
// ----------------------------------------------------------------------------
module lmcs_frame_buffer #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lmcs_pkg::t_fb_wr           i_wr,
    input  logic [$clog2(COLUMNS)-1:0] i_rd_addr,
    output logic [ROWS-1:0]            o_rd_data
);
    import lmcs_pkg::*;

    logic [ROWS-1:0] r_mem [COLUMNS];
    logic [31:0]     wr_col;
    logic [31:0]     wr_row;

    assign wr_col    = 32'(i_wr.column);
    assign wr_row    = 32'(i_wr.row);
    assign o_rd_data = r_mem[i_rd_addr];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < COLUMNS; c++) begin
            if (!i_rst_n || i_wr.clear) begin
                r_mem[c] <= '0;
            end else if (i_wr.write && wr_col == 32'(c)) begin
                for (int r = 0; r < ROWS; r++) begin
                    if (wr_row == 32'(r)) begin
                        r_mem[c][r] <= i_wr.pixel_on;
                    end
                end
            end
        end
    end

endmodule

@@ design/lmcs_sequencer.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan sequencer
// Steps the row shift, latch, column clock and dwell phases, one step per
// scan tick, and presents the pin levels after each step.
// ----------------------------------------------------------------------------
module lmcs_sequencer #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic [lmcs_pkg::DWELL_W-1:0]   i_dwell_ticks,
    input  logic [ROWS-1:0]                i_col_data,
    output logic [$clog2(COLUMNS)-1:0]     o_rd_addr,
    output lmcs_pkg::t_pins                o_next_pins,
    output logic [lmcs_pkg::SCAN_W-1:0]    o_next_column
);
    import lmcs_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int PH_W  = $clog2(2 * ROWS + 5);

    localparam logic [PH_W-1:0]  PH_LATCH_LOW  = PH_W'(2 * ROWS);
    localparam logic [PH_W-1:0]  PH_LATCH_HIGH = PH_W'(2 * ROWS + 1);
    localparam logic [PH_W-1:0]  PH_COL_LOW    = PH_W'(2 * ROWS + 2);
    localparam logic [PH_W-1:0]  PH_COL_HIGH   = PH_W'(2 * ROWS + 3);
    localparam logic [PH_W-1:0]  PH_DWELL      = PH_W'(2 * ROWS + 4);
    localparam logic [COL_W-1:0] LAST_COLUMN   = COL_W'(COLUMNS - 1);

    logic [PH_W-1:0]    r_phase,  n_phase;
    logic [COL_W-1:0]   r_column, n_column;
    logic [DWELL_W-1:0] r_dwell,  n_dwell;
    logic [ROWS-1:0]    r_shift,  n_shift;
    t_pins              r_pins,   n_pins;
    logic [DWELL_W-1:0] dwell_inc;
    logic [COL_W-1:0]   column_inc;
    logic [31:0]        column_ext;

    assign dwell_inc  = r_dwell + DWELL_W'(1);
    assign column_inc = (r_column == LAST_COLUMN) ? '0 : r_column + COL_W'(1);
    assign column_ext = 32'(n_column);

    assign o_rd_addr     = r_column;
    assign o_next_pins   = n_pins;
    assign o_next_column = column_ext[SCAN_W-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_column = r_column;
        n_dwell  = r_dwell;
        n_shift  = r_shift;
        n_pins   = r_pins;
        if (i_tick) begin
            if (r_phase < PH_LATCH_LOW) begin
                if (!r_phase[0]) begin
                    n_pins.row_clock = 1'b0;
                    if (r_phase == '0) begin
                        n_shift         = i_col_data;
                        n_pins.row_data = i_col_data[0];
                    end else begin
                        n_pins.row_data = r_shift[0];
                    end
                end else begin
                    n_pins.row_clock = 1'b1;
                    n_shift          = r_shift >> 1;
                end
                n_phase = r_phase + PH_W'(1);
            end else if (r_phase == PH_LATCH_LOW) begin
                n_pins.latch = 1'b0;
                n_phase      = r_phase + PH_W'(1);
            end else if (r_phase == PH_LATCH_HIGH) begin
                n_pins.latch = 1'b1;
                n_phase      = r_phase + PH_W'(1);
            end else if (r_phase == PH_COL_LOW) begin
                n_pins.col_clock = 1'b0;
                n_pins.col_data  = (r_column == '0);
                n_phase          = r_phase + PH_W'(1);
            end else if (r_phase == PH_COL_HIGH) begin
                n_pins.col_clock = 1'b1;
                n_dwell          = '0;
                if (i_dwell_ticks == '0) begin
                    n_column = column_inc;
                    n_phase  = '0;
                end else begin
                    n_phase = PH_DWELL;
                end
            end else begin
                if (dwell_inc >= i_dwell_ticks || dwell_inc == '0) begin
                    n_column = column_inc;
                    n_phase  = '0;
                    n_dwell  = '0;
                end else begin
                    n_dwell = dwell_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_column <= '0;
            r_dwell  <= '0;
            r_shift  <= '0;
            r_pins   <= PINS_RESET;
        end else begin
            r_phase  <= n_phase;
            r_column <= n_column;
            r_dwell  <= n_dwell;
            r_shift  <= n_shift;
            r_pins   <= n_pins;
        end
    end

endmodule

@@ design/led_matrix_column_scanner.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scanner
// Frame buffer and scan sequencer that drive a row shift register and a
// column shift chain for a multiplexed LED matrix.
// ----------------------------------------------------------------------------
// Each command transaction on i_cmd writes one pixel, clears the frame
// buffer, or advances the scan by one tick; any other command code only
// reports. Every command transaction yields exactly one result transaction
// on o_result that carries the pin levels and scan column after the command.
// i_cfg_we with i_cfg_wdata sets the dwell length in ticks; write it only
// while no transaction is in flight.
// A transaction is captured in an input register and, once the result register
// is free, worked through into the result register. One transaction is taken
// per cycle while the receiver takes results; this rate is set by the single
// pass from the input register through the frame buffer read and the phase
// logic into the result register.
// When the receiver stalls, the result holds, one more transaction can wait
// in the input register, and i_cmd.ready then falls.
// Synchronous reset clears the frame buffer, puts the scan at column 0 with
// the latch pin high and the other pins low, and sets the dwell to 500.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lmcs_cmd_if.sink                     i_cmd,
    lmcs_res_if.source                   o_result,
    input  logic                         i_cfg_we,
    input  logic [lmcs_pkg::DWELL_W-1:0] i_cfg_wdata
);
    import lmcs_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);

    logic                r_in_valid;
    logic [CMD_W-1:0]    r_command;
    logic [COLUMN_W-1:0] r_column;
    logic [ROW_W-1:0]    r_row;
    logic                r_pixel_on;
    logic                r_out_valid;
    t_pins               r_out_pins;
    logic [SCAN_W-1:0]   r_out_column;
    logic [DWELL_W-1:0]  r_dwell_ticks;

    logic                in_accept;
    logic                advance;
    t_fb_wr              fb_wr;
    logic [COL_W-1:0]    rd_addr;
    logic [ROWS-1:0]     rd_data;
    t_pins               next_pins;
    logic [SCAN_W-1:0]   next_column;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_cmd.ready  = !r_in_valid || advance;
    assign in_accept    = i_cmd.valid && i_cmd.ready;

    assign fb_wr.write    = advance && (r_command == CMD_WRITE);
    assign fb_wr.clear    = advance && (r_command == CMD_CLEAR);
    assign fb_wr.column   = r_column;
    assign fb_wr.row      = r_row;
    assign fb_wr.pixel_on = r_pixel_on;

    lmcs_frame_buffer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_frame_buffer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fb_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lmcs_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sequencer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (advance && (r_command == CMD_TICK)),
        .i_dwell_ticks (r_dwell_ticks),
        .i_col_data    (rd_data),
        .o_rd_addr     (rd_addr),
        .o_next_pins   (next_pins),
        .o_next_column (next_column)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_dwell_ticks <= DWELL_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_dwell_ticks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command  <= i_cmd.command;
            r_column   <= i_cmd.column;
            r_row      <= i_cmd.row;
            r_pixel_on <= i_cmd.pixel_on;
        end
        if (advance) begin
            r_out_pins   <= next_pins;
            r_out_column <= next_column;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.row_data_pin     = r_out_pins.row_data;
    assign o_result.row_clock_pin    = r_out_pins.row_clock;
    assign o_result.latch_pin        = r_out_pins.latch;
    assign o_result.column_data_pin  = r_out_pins.col_data;
    assign o_result.column_clock_pin = r_out_pins.col_clock;
    assign o_result.scan_column      = r_out_column;

endmodule

@@ design/lmcs_checker.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scanner checker
// Port-level checks on result timing, backpressure and pin ordering.
// ----------------------------------------------------------------------------
module lmcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_row_data_pin,
    input logic                        i_row_clock_pin,
    input logic                        i_latch_pin,
    input logic                        i_column_data_pin,
    input logic                        i_column_clock_pin,
    input logic [lmcs_pkg::SCAN_W-1:0] i_scan_column
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("Accepted transaction produced no result in time.");

    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("Input stalled without a stalled result.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_row_data_pin)
            && $stable(i_row_clock_pin) && $stable(i_latch_pin)
            && $stable(i_column_data_pin) && $stable(i_column_clock_pin)
            && $stable(i_scan_column)))
        else $error("Stalled result changed.");

    a_latch_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_latch_pin) |-> i_row_clock_pin)
        else $error("Latch pulsed while the row clock was low.");

    a_column_data_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_column_data_pin) |-> (i_scan_column <= 5'd1))
        else $error("Column data high away from the first columns.");

endmodule

bind led_matrix_column_scanner lmcs_checker u_lmcs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_cmd.valid),
    .i_in_ready         (i_cmd.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_row_data_pin     (o_result.row_data_pin),
    .i_row_clock_pin    (o_result.row_clock_pin),
    .i_latch_pin        (o_result.latch_pin),
    .i_column_data_pin  (o_result.column_data_pin),
    .i_column_clock_pin (o_result.column_clock_pin),
    .i_scan_column      (o_result.scan_column)
);

@@ dv/led_matrix_column_scanner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix column scanner testbench
// Drives pixel writes, buffer clears and scan ticks into the scanner under
// random idling and backpressure, predicts the pin levels of every result
// transaction from an internal scan model and compares them in order.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner_tb;
    import lmcs_pkg::*;

    localparam int COLUMNS          = 32;
    localparam int ROWS             = 8;
    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int MAX_REPORTS      = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int PH_LATCH_LOW  = 2 * ROWS;
    localparam int PH_LATCH_HIGH = 2 * ROWS + 1;
    localparam int PH_COL_LOW    = 2 * ROWS + 2;
    localparam int PH_COL_HIGH   = 2 * ROWS + 3;
    localparam int PH_DWELL      = 2 * ROWS + 4;

    typedef struct packed {
        t_pins               pins;
        logic [SCAN_W-1:0]   column;
    } t_scan_levels;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [DWELL_W-1:0] i_cfg_wdata;

    lmcs_cmd_if cmd_if();
    lmcs_res_if res_if();

    led_matrix_column_scanner #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [ROWS-1:0]    frame_model [COLUMNS];
    logic [SCAN_W-1:0]  scan_column;
    logic [4:0]         scan_phase;
    logic [DWELL_W-1:0] dwell_count;
    logic [DWELL_W-1:0] dwell_ticks;
    logic [ROWS-1:0]    shift_byte;
    t_pins              pin_levels;

    t_scan_levels pending_levels[$];
    int           mismatch_count = 0;
    bit           idle_en = 1'b1;
    bit           long_hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic reset_scan_model();
        foreach (frame_model[c]) begin
            frame_model[c] = '0;
        end
        scan_column = '0;
        scan_phase  = '0;
        dwell_count = '0;
        dwell_ticks = DWELL_RESET;
        shift_byte  = '0;
        pin_levels  = PINS_RESET;
    endtask

    task automatic next_column();
        scan_column = (scan_column == SCAN_W'(COLUMNS - 1)) ? '0 : scan_column + 1'b1;
        scan_phase  = '0;
        dwell_count = '0;
    endtask

    task automatic advance_scan();
        if (scan_phase < PH_LATCH_LOW) begin
            if (!scan_phase[0]) begin
                if (scan_phase == 0) begin
                    shift_byte = frame_model[scan_column];
                end
                pin_levels.row_clock = 1'b0;
                pin_levels.row_data  = shift_byte[0];
            end else begin
                pin_levels.row_clock = 1'b1;
                shift_byte = shift_byte >> 1;
            end
            scan_phase = scan_phase + 1'b1;
        end else if (scan_phase == PH_LATCH_LOW) begin
            pin_levels.latch = 1'b0;
            scan_phase = scan_phase + 1'b1;
        end else if (scan_phase == PH_LATCH_HIGH) begin
            pin_levels.latch = 1'b1;
            scan_phase = scan_phase + 1'b1;
        end else if (scan_phase == PH_COL_LOW) begin
            pin_levels.col_clock = 1'b0;
            pin_levels.col_data  = (scan_column == 0);
            scan_phase = scan_phase + 1'b1;
        end else if (scan_phase == PH_COL_HIGH) begin
            pin_levels.col_clock = 1'b1;
            dwell_count = '0;
            if (dwell_ticks == 0) begin
                next_column();
            end else begin
                scan_phase = 5'(PH_DWELL);
            end
        end else begin
            dwell_count = dwell_count + 1'b1;
            if (dwell_count >= dwell_ticks || dwell_count == 0) begin
                next_column();
            end
        end
    endtask

    task automatic predict_levels(input logic [CMD_W-1:0] cmd, input logic [COLUMN_W-1:0] col,
                                  input logic [ROW_W-1:0] row, input logic on);
        case (cmd)
            CMD_WRITE: begin
                frame_model[col][row] = on;
            end
            CMD_CLEAR: begin
                foreach (frame_model[c]) begin
                    frame_model[c] = '0;
                end
            end
            CMD_TICK: begin
                advance_scan();
            end
            default: begin
            end
        endcase
        pending_levels.push_back('{pins: pin_levels, column: scan_column});
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [COLUMN_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic on);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= cmd;
        cmd_if.column   <= col;
        cmd_if.row      <= row;
        cmd_if.pixel_on <= on;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_levels(cmd, col, row, on);
    endtask

    task automatic send_random(input int tick_pct, input int count);
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
                cmd = CMD_TICK;
            end else if (pick < 98) begin
                cmd = CMD_WRITE;
            end else if (pick == 98) begin
                cmd = CMD_CLEAR;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_command(cmd, COLUMN_W'($urandom), ROW_W'($urandom),
                         $urandom_range(0, 2) != 0);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_command(CMD_TICK, COLUMN_W'($urandom), ROW_W'($urandom), 1'b0);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_dwell(input logic [DWELL_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dwell_ticks = value;
    endtask

    task automatic test_pixel_writes();
        send_command(CMD_UNUSED, 5'd31, 3'd7, 1'b1);
        send_command(CMD_CLEAR, 5'd0, 3'd0, 1'b0);
        send_command(CMD_WRITE, 5'd0, 3'd0, 1'b1);
        send_command(CMD_WRITE, 5'd0, 3'd7, 1'b1);
        send_command(CMD_WRITE, 5'd0, 3'd3, 1'b1);
        send_command(CMD_WRITE, 5'd0, 3'd3, 1'b0);
        send_command(CMD_WRITE, 5'd31, 3'd7, 1'b1);
        send_command(CMD_WRITE, 5'd31, 3'd0, 1'b1);
        send_command(CMD_WRITE, 5'd31, 3'd7, 1'b0);
    endtask

    task automatic test_default_dwell();
        send_ticks(PH_DWELL + 2);
    endtask

    task automatic test_dwell_change();
        write_dwell(16'd3);
        send_ticks(4);
        write_dwell(16'hFFFF);
        send_ticks(PH_DWELL + 40);
        write_dwell(16'd30);
        send_ticks(3);
        write_dwell(16'd0);
        send_ticks(PH_DWELL + 2);
    endtask

    task automatic test_column_wrap();
        write_dwell(16'd0);
        send_random(92, 800);
    endtask

    task automatic test_backpressure();
        write_dwell(16'd1);
        long_hold_req = 1'b1;
        send_random(70, 300);
        drain_results();
        send_random(70, 20);
        write_dwell(16'($urandom_range(2, 15)));
        send_random(75, 230);
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        write_dwell(16'd7);
        send_random(80, 300);
    endtask

    always @(posedge i_clk) begin
        t_scan_levels seen;
        t_scan_levels want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen = '{pins: '{row_data:  res_if.row_data_pin,
                             row_clock: res_if.row_clock_pin,
                             latch:     res_if.latch_pin,
                             col_data:  res_if.column_data_pin,
                             col_clock: res_if.column_clock_pin},
                     column: res_if.scan_column};
            if (pending_levels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result transaction pins=%b column=%0d",
                             $realtime, seen.pins, seen.column);
                end
            end else begin
                want = pending_levels.pop_front();
                if (seen.pins !== want.pins || seen.column !== want.column) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: pins expected %b got %b, column expected %0d got %0d",
                                 $realtime, want.pins, seen.pins, want.column, seen.column);
                    end
                end
            end
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 6) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        cmd_if.valid    <= 1'b0;
        cmd_if.command  <= CMD_WRITE;
        cmd_if.column   <= '0;
        cmd_if.row      <= '0;
        cmd_if.pixel_on <= 1'b0;
        reset_scan_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pixel_writes();
        test_default_dwell();
        test_dwell_change();
        test_column_wrap();
        test_backpressure();
        test_no_idle();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("led_matrix_column_scanner verification clean");
        end else begin
            $display("led_matrix_column_scanner verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("led_matrix_column_scanner verification failed");
        $finish;
    end

endmodule
